// ===== hdl/rbwp_pkg.sv =====
`timescale 1ns / 1ps
package rbwp_pkg;

  // default parameter values
  localparam int ANGLE_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 16;

  // cordic datapath: q30 values and 2^32-per-turn angles in 34 signed bits
  localparam int CORDIC_ITERS = 30;
  localparam int CORDIC_Q     = 30;
  localparam int CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN_INIT = 34'sd652032874;

  // widths of the result arithmetic
  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 16;
  localparam int COORD_W = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSE_X       = 2'd0,
    CFG_POSE_Y       = 2'd1,
    CFG_POSE_HEADING = 2'd2,
    CFG_MAX_RANGE    = 2'd3
  } cfg_idx_t;

  localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 16'hFFFF;

  // input item
  typedef struct packed {
    logic        [RANGE_W-1:0] range_value;
    logic signed [ANGLE_W-1:0] beam_angle;
    logic signed [ANGLE_W-1:0] mount_rotation;
  } in_t;

  // result item
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      at_max_range;
  } out_t;

  // sideband that rides along the pipeline with each beam
  typedef struct packed {
    logic [RANGE_W-1:0] range_value;
    logic               flip;
    logic               at_max;
  } side_t;

  // arctangent of 2^-i in 2^32 units per turn
  function automatic logic signed [CW-1:0] atan_turn(input int idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      24: v = 34'sd41;
      25: v = 34'sd20;
      26: v = 34'sd10;
      27: v = 34'sd5;
      28: v = 34'sd3;
      29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/rbwp_cordic.sv =====
`timescale 1ns / 1ps
module rbwp_cordic (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [rbwp_pkg::CW-1:0]         in_z,
  input  rbwp_pkg::side_t                        in_side,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [rbwp_pkg::CW-1:0]         out_x,
  output logic signed [rbwp_pkg::CW-1:0]         out_y,
  output rbwp_pkg::side_t                        out_side
);

  localparam int N  = rbwp_pkg::CORDIC_ITERS;
  localparam int CW = rbwp_pkg::CW;

  // chain views: index i feeds iteration stage i, index N is the last stage
  logic signed [CW-1:0] xc [0:N];
  logic signed [CW-1:0] yc [0:N];
  logic signed [CW-1:0] zc [0:N];
  rbwp_pkg::side_t      sc [0:N];
  logic                 vc [0:N];
  logic                 rdy [0:N];

  assign xc[0]  = rbwp_pkg::CORDIC_GAIN_INIT;
  assign yc[0]  = '0;
  assign zc[0]  = in_z;
  assign sc[0]  = in_side;
  assign vc[0]  = in_valid;
  assign rdy[N] = out_ready;
  assign in_ready = rdy[0];

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [CW-1:0] x_r, y_r, z_r;
    logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;
    logic signed [CW-1:0] xs, ys;
    rbwp_pkg::side_t      side_r;
    logic                 v_r;

    // one micro-rotation toward z = 0
    always_comb begin
      xs = xc[i] >>> i;
      ys = yc[i] >>> i;
      if (!zc[i][CW-1]) begin
        x_nxt = xc[i] - ys;
        y_nxt = yc[i] + xs;
        z_nxt = zc[i] - rbwp_pkg::atan_turn(i);
      end else begin
        x_nxt = xc[i] + ys;
        y_nxt = yc[i] - xs;
        z_nxt = zc[i] + rbwp_pkg::atan_turn(i);
      end
    end

    // stage advances when empty or when the next one moves
    assign rdy[i] = !v_r || rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (rdy[i]) begin
        v_r <= vc[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && vc[i]) begin
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        z_r    <= z_nxt;
        side_r <= sc[i];
      end
    end

    assign xc[i+1] = x_r;
    assign yc[i+1] = y_r;
    assign zc[i+1] = z_r;
    assign sc[i+1] = side_r;
    assign vc[i+1] = v_r;
  end

  assign out_valid = vc[N];
  assign out_x     = xc[N];
  assign out_y     = yc[N];
  assign out_side  = sc[N];

endmodule

// ===== hdl/range_beam_to_world_point_top.sv =====
`timescale 1ns / 1ps
// range beam to world point
// in_data carries one beam (range, beam angle, mount rotation) per transfer on
// in_valid/in_ready; out_data carries the world point and max-range flag on
// out_valid/out_ready, one result per beam, in order.
// the cfg port writes pose x, pose y, heading and max range (index 0..3) with
// cfg_we; write only while no beam is in flight.
// from input transfer to out_valid a beam passes one angle stage, 30 cordic
// iteration stages, then trig rounding, multiply, product rounding and the
// saturating add into the output register.
// throughput is one beam per cycle while out_ready holds; each stage takes a
// new beam when it is empty or its successor moves, so bubbles close up.
// when the receiver stalls, results back up stage by stage and in_ready drops
// only once every stage holds a beam; nothing is lost or repeated.
// reset (rst_n low, synchronous) empties the pipeline and sets pose and
// heading to zero and max range to 65535.
module range_beam_to_world_point_top #(
  parameter int ANGLE_BITS     = rbwp_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = rbwp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rbwp_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rbwp_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [rbwp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbwp_pkg::CFG_W-1:0]        cfg_data
);

  localparam int CW  = rbwp_pkg::CW;
  localparam int F   = TRIG_FRAC_BITS;
  localparam int TW  = F + 2;
  localparam int PW  = rbwp_pkg::RANGE_W + 1 + TW;
  localparam int RW  = rbwp_pkg::RANGE_W + 2;
  localparam int RS  = rbwp_pkg::CORDIC_Q - F;
  localparam int SW  = rbwp_pkg::COORD_W + 2;
  localparam logic signed [CW-1:0] TRIG_RND = CW'(1) << (RS - 1);
  localparam logic signed [CW-1:0] TRIG_LIM = CW'(1) << F;
  localparam logic signed [PW-1:0] PROD_RND = PW'(1) << (F - 1);
  localparam logic signed [SW-1:0] SAT_MAX  = SW'(34'sd2147483647);
  localparam logic signed [SW-1:0] SAT_MIN  = -SW'(34'sd2147483648);

  // configuration registers
  logic signed [rbwp_pkg::COORD_W-1:0] pose_x_r, pose_y_r;
  logic signed [rbwp_pkg::ANGLE_W-1:0] heading_r;
  logic [rbwp_pkg::RANGE_W-1:0]        max_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      heading_r   <= '0;
      max_range_r <= rbwp_pkg::MAX_RANGE_RST;
    end else if (cfg_we) begin
      case (rbwp_pkg::cfg_idx_t'(cfg_index))
        rbwp_pkg::CFG_POSE_X:       pose_x_r    <= cfg_data;
        rbwp_pkg::CFG_POSE_Y:       pose_y_r    <= cfg_data;
        rbwp_pkg::CFG_POSE_HEADING: heading_r   <= cfg_data[rbwp_pkg::ANGLE_W-1:0];
        rbwp_pkg::CFG_MAX_RANGE:    max_range_r <= cfg_data[rbwp_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage ready chain
  logic a_rdy, cor_in_ready, r_rdy, m_rdy, p_rdy, o_rdy;
  logic a_v_r, cor_v, r_v_r, m_v_r, p_v_r, o_v_r;

  assign o_rdy    = !o_v_r || out_ready;
  assign p_rdy    = !p_v_r || o_rdy;
  assign m_rdy    = !m_v_r || p_rdy;
  assign r_rdy    = !r_v_r || m_rdy;
  assign a_rdy    = !a_v_r || cor_in_ready;
  assign in_ready = a_rdy;

  // angle stage: wrapped angle sum, half-turn fold, max-range compare
  logic [31:0]          ang_sum, turn, turn_q, turn_t;
  logic                 flip;
  logic signed [CW-1:0] a_z_nxt, a_z_r;
  rbwp_pkg::side_t      a_side_nxt, a_side_r;

  always_comb begin
    ang_sum = 32'(in_data.beam_angle) + 32'(in_data.mount_rotation) + 32'(heading_r);
    turn    = ang_sum << (32 - ANGLE_BITS);
    turn_q  = turn + 32'h4000_0000;
    flip    = turn_q[31];
    turn_t  = flip ? (turn + 32'h8000_0000) : turn;
    a_z_nxt = {{(CW-32){turn_t[31]}}, turn_t};
    a_side_nxt.range_value = in_data.range_value;
    a_side_nxt.flip        = flip;
    a_side_nxt.at_max      = (in_data.range_value >= max_range_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_z_r    <= a_z_nxt;
      a_side_r <= a_side_nxt;
    end
  end

  // cordic iterations
  logic signed [CW-1:0] cor_x, cor_y;
  rbwp_pkg::side_t      cor_side;

  rbwp_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_v_r),
    .in_ready  (cor_in_ready),
    .in_z      (a_z_r),
    .in_side   (a_side_r),
    .out_valid (cor_v),
    .out_ready (r_rdy),
    .out_x     (cor_x),
    .out_y     (cor_y),
    .out_side  (cor_side)
  );

  // trig stage: round q30 to F fraction bits, clamp, undo the fold
  logic signed [CW-1:0] xq, yq;
  logic signed [TW-1:0] c_nxt, s_nxt, c_r, s_r;
  rbwp_pkg::side_t      r_side_r;

  always_comb begin
    xq = (cor_x + TRIG_RND) >>> RS;
    yq = (cor_y + TRIG_RND) >>> RS;
    if (xq > TRIG_LIM)  xq = TRIG_LIM;
    if (xq < -TRIG_LIM) xq = -TRIG_LIM;
    if (yq > TRIG_LIM)  yq = TRIG_LIM;
    if (yq < -TRIG_LIM) yq = -TRIG_LIM;
    if (cor_side.flip) begin
      xq = -xq;
      yq = -yq;
    end
    c_nxt = xq[TW-1:0];
    s_nxt = yq[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (r_rdy) begin
      r_v_r <= cor_v;
    end
  end

  always_ff @(posedge clk) begin
    if (r_rdy && cor_v) begin
      c_r      <= c_nxt;
      s_r      <= s_nxt;
      r_side_r <= cor_side;
    end
  end

  // multiply stage
  logic signed [PW-1:0] mx_nxt, my_nxt, mx_r, my_r;
  logic signed [rbwp_pkg::RANGE_W:0] range_s;
  logic                 m_at_max_r;

  always_comb begin
    range_s = $signed({1'b0, r_side_r.range_value});
    mx_nxt  = range_s * c_r;
    my_nxt  = range_s * s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (m_rdy) begin
      m_v_r <= r_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy && r_v_r) begin
      mx_r       <= mx_nxt;
      my_r       <= my_nxt;
      m_at_max_r <= r_side_r.at_max;
    end
  end

  // product rounding stage, half up to whole range units
  logic signed [PW-1:0] px_full, py_full;
  logic signed [RW-1:0] px_nxt, py_nxt, px_r, py_r;
  logic                 p_at_max_r;

  always_comb begin
    px_full = (mx_r + PROD_RND) >>> F;
    py_full = (my_r + PROD_RND) >>> F;
    px_nxt  = px_full[RW-1:0];
    py_nxt  = py_full[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (p_rdy) begin
      p_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_rdy && m_v_r) begin
      px_r       <= px_nxt;
      py_r       <= py_nxt;
      p_at_max_r <= m_at_max_r;
    end
  end

  // output stage: add the pose and saturate to 32 bits
  logic signed [SW-1:0] sx, sy;
  rbwp_pkg::out_t       o_nxt, o_data_r;

  always_comb begin
    sx = {{(SW-rbwp_pkg::COORD_W){pose_x_r[rbwp_pkg::COORD_W-1]}}, pose_x_r}
       + {{(SW-RW){px_r[RW-1]}}, px_r};
    sy = {{(SW-rbwp_pkg::COORD_W){pose_y_r[rbwp_pkg::COORD_W-1]}}, pose_y_r}
       + {{(SW-RW){py_r[RW-1]}}, py_r};
    if (sx > SAT_MAX) sx = SAT_MAX;
    if (sx < SAT_MIN) sx = SAT_MIN;
    if (sy > SAT_MAX) sy = SAT_MAX;
    if (sy < SAT_MIN) sy = SAT_MIN;
    o_nxt.point_x      = sx[rbwp_pkg::COORD_W-1:0];
    o_nxt.point_y      = sy[rbwp_pkg::COORD_W-1:0];
    o_nxt.at_max_range = p_at_max_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_rdy) begin
      o_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && p_v_r) begin
      o_data_r <= o_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_data_r;

endmodule
